FILE: sv/rsa_pkg.sv
// shared types, constants and helpers for the running statistics accumulator
package rsa_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int MEAN_EXTRA    = 16;
  localparam int TIME_W        = 48;
  localparam int ACC_W         = 64;
  localparam int CNT_W         = 32;
  localparam int MEAN_W        = VALUE_WIDTH + MEAN_EXTRA;
  localparam int ROOT_W        = ACC_W / 2;
  localparam int SEL_W         = 4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] INTEGRAL_DEN   = ACC_W'(2000);

  typedef enum logic [SEL_W-1:0] {
    AGG_COUNT     = 4'd0,
    AGG_SUM       = 4'd1,
    AGG_MEAN      = 4'd2,
    AGG_MIN       = 4'd3,
    AGG_MAX       = 4'd4,
    AGG_RANGE     = 4'd5,
    AGG_STDDEV    = 4'd6,
    AGG_VAR       = 4'd7,
    AGG_SSTDDEV   = 4'd8,
    AGG_SVAR      = 4'd9,
    AGG_TIME_AVG  = 4'd10,
    AGG_RATE      = 4'd11,
    AGG_INTEGRAL  = 4'd12
  } agg_sel_e;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] sample_value;
    logic [TIME_W-1:0]             sample_time_ms;
    logic                          window_restart;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] aggregate_value;
    logic                    aggregate_valid;
    logic [CNT_W-1:0]        samples_seen;
  } out_item_t;

  function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    return m;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_signed(input logic [ACC_W-1:0] m,
                                                         input logic neg);
    logic signed [ACC_W-1:0] r;
    if (neg) begin
      r = m[ACC_W-1] ? ACC_MIN : -$signed(m);
    end else begin
      r = m[ACC_W-1] ? ACC_MAX : $signed(m);
    end
    return r;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W-1:0] r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/rsa_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle
module rsa_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsa_pkg::ACC_W-1:0]  a_i,
  input  logic [rsa_pkg::ACC_W-1:0]  b_i,
  output logic                       busy_o,
  output logic [2*rsa_pkg::ACC_W-1:0] prod_o
);
  import rsa_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);

  logic [CW-1:0]        cnt_q, cnt_d;
  logic [ACC_W-1:0]     a_q;
  logic [2*ACC_W-1:0]   p_q, p_d;
  logic [ACC_W:0]       acc;

  always_comb begin
    acc = {1'b0, p_q[2*ACC_W-1:ACC_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {acc, p_q[ACC_W-1:1]};
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CW'(ACC_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{ACC_W{1'b0}}, b_i};
    end else if (cnt_q != '0) begin
      p_q <= p_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign prod_o = p_q;

endmodule

FILE: sv/rsa_div.sv
// restoring divider, one quotient bit per cycle
module rsa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsa_pkg::ACC_W-1:0] num_i,
  input  logic [rsa_pkg::ACC_W-1:0] den_i,
  output logic                      busy_o,
  output logic [rsa_pkg::ACC_W-1:0] quo_o
);
  import rsa_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [ACC_W-1:0] den_q, quo_q, rem_q;
  logic [ACC_W:0]   shifted;
  logic [ACC_W+1:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[ACC_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_q};
    ge      = !diff[ACC_W+1];
    cnt_d   = cnt_q;
    if (start_i) begin
      cnt_d = CW'(ACC_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      quo_q <= num_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[ACC_W-1:0] : shifted[ACC_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule

FILE: sv/rsa_sqrt.sv
// digit-by-digit square root, two radicand bits per cycle, rounded to nearest
module rsa_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsa_pkg::ACC_W-1:0]  rad_i,
  output logic                       busy_o,
  output logic [rsa_pkg::ROOT_W:0]   root_o
);
  import rsa_pkg::*;

  localparam int CW    = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 3;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [ACC_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, r2, trial;
  logic [ROOT_W-1:0] root_q;
  logic              ge;

  always_comb begin
    r2    = {rem_q[REM_W-3:0], rad_q[ACC_W-1:ACC_W-2]};
    trial = {1'b0, root_q, 2'b01};
    ge    = (r2 >= trial);
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = CW'(ROOT_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= {rad_q[ACC_W-3:0], 2'b00};
      rem_q  <= ge ? (r2 - trial) : r2;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = {1'b0, root_q} + ((rem_q > REM_W'(root_q)) ? (ROOT_W+1)'(1) : '0);

endmodule

FILE: sv/running_stats_accumulator.sv
// running statistics accumulator: welford mean and variance, min, max, integral
//
// usage: one sample transaction in (value, timestamp, window restart flag),
// one result transaction out (selected aggregate, valid flag, sample count).
// in_stall_o is high while a sample is being worked on; one sample at a time.
// the aggregate is chosen by the configuration register, written through
// cfg_valid_i / cfg_ready_o; the user must write it only while no sample is
// in progress, as the block itself does not enforce this. count, sum, mean,
// min, max, range and invalid results are selected directly; the divided
// aggregates pass through the serial divider, and the standard deviations
// through the divider and then the square root. the serial multiplier and
// divider work one bit per cycle. a new sample is taken only once the last
// one's result has moved to the output register, later if the output stalls.
// reset clears all window state and selects the mean.
// a finished result waits in the output register while out_stall_i is high;
// a new sample is taken meanwhile, and its result holds until the register
// frees up.
module running_stats_accumulator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rsa_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rsa_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsa_pkg::SEL_W-1:0]     cfg_data_i
);
  import rsa_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_PREP   = 10'b0000000010,
    ST_FIRST  = 10'b0000000100,
    ST_WAIT1  = 10'b0000001000,
    ST_M2ST   = 10'b0000010000,
    ST_M2WAIT = 10'b0000100000,
    ST_OUTSEL = 10'b0001000000,
    ST_OUTDIV = 10'b0010000000,
    ST_SQRT   = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  agg_sel_e sel_q;

  logic signed [VALUE_WIDTH-1:0] x_q, least_q, greatest_q, first_q, prev_q;
  logic [TIME_W-1:0]             t_q, prev_time_q, elapsed_q;
  logic                          restart_q;
  logic [CNT_W-1:0]              total_q;
  logic signed [MEAN_W-1:0]      mean_q;
  logic signed [ACC_W-1:0]       m2_q, sum_q, trap_q;
  logic                          trap_en_q, s_neg_q, div_neg_q, sqrt_q;
  logic signed [MEAN_W:0]        delta_q;
  logic signed [ACC_W-1:0]       res_val_q;
  logic                          res_valid_q;
  logic                          out_valid_q;
  out_item_t                     out_data_q;

  // unit handshakes
  logic                  mul_start, div_start, sqrt_start;
  logic                  mul_busy, div_busy, sqrt_busy;
  logic [ACC_W-1:0]      mul_a, mul_b, div_num, div_den, sqrt_rad;
  logic [2*ACC_W-1:0]    mul_p;
  logic [ACC_W-1:0]      div_q;
  logic [ROOT_W:0]       sqrt_root;

  // first-step datapath
  logic                   first_win, trap_hit;
  logic [TIME_W-1:0]      dt, el_next;
  logic [TIME_W:0]        el_sum;
  logic signed [VALUE_WIDTH:0] s;
  logic [VALUE_WIDTH:0]   s_mag;
  logic [CNT_W-1:0]       n_new;
  logic signed [MEAN_W-1:0] scaled;
  logic signed [MEAN_W:0] delta, delta2;
  logic [MEAN_W:0]        delta_mag, delta2_mag, q49;
  logic signed [ACC_W-1:0] x64;
  logic signed [MEAN_W:0] mean_sum;
  logic [ACC_W-1:0]       tmag, inc, room;

  // output selection
  logic                   o_direct, o_valid, o_neg, o_sqrt;
  logic signed [ACC_W-1:0] o_val, rate_d, rate_num;
  logic [ACC_W-1:0]       o_mag, o_den, n64, nm164;
  logic [MEAN_W-1:0]      mean_mag;
  logic [MEAN_W:0]        mean_rnd;

  always_comb begin
    first_win = (total_q == '0);
    dt        = t_q - prev_time_q;
    trap_hit  = !first_win && (t_q > prev_time_q);
    s         = {prev_q[VALUE_WIDTH-1], prev_q} + {x_q[VALUE_WIDTH-1], x_q};
    s_mag     = s[VALUE_WIDTH] ? (~s + (VALUE_WIDTH+1)'(1)) : s;
    el_sum    = {1'b0, elapsed_q} + {1'b0, dt};
    el_next   = el_sum[TIME_W] ? {TIME_W{1'b1}} : el_sum[TIME_W-1:0];
    n_new     = (total_q == {CNT_W{1'b1}}) ? total_q : total_q + CNT_W'(1);
    scaled    = {x_q, {MEAN_EXTRA{1'b0}}};
    delta     = {scaled[MEAN_W-1], scaled} - {mean_q[MEAN_W-1], mean_q};
    delta_mag = delta[MEAN_W] ? (~delta + (MEAN_W+1)'(1)) : delta;
    delta2    = {scaled[MEAN_W-1], scaled} - {mean_q[MEAN_W-1], mean_q};
    delta2_mag = delta2[MEAN_W] ? (~delta2 + (MEAN_W+1)'(1)) : delta2;
    x64       = {{(ACC_W-VALUE_WIDTH){x_q[VALUE_WIDTH-1]}}, x_q};
    q49       = div_q[MEAN_W:0];
    mean_sum  = {mean_q[MEAN_W-1], mean_q} +
                (delta_q[MEAN_W] ? (~q49 + (MEAN_W+1)'(1)) : q49);
    tmag      = (mul_p[2*ACC_W-1:ACC_W] != '0) ? {ACC_W{1'b1}} : mul_p[ACC_W-1:0];
    inc       = (mul_p[2*ACC_W-1:ACC_W+32] != '0) ? {ACC_W{1'b1}} : mul_p[ACC_W+31:32];
    room      = ACC_MAX - m2_q;
  end

  always_comb begin
    o_direct = 1'b1;
    o_valid  = 1'b0;
    o_val    = '0;
    o_mag    = '0;
    o_den    = '0;
    o_neg    = 1'b0;
    o_sqrt   = 1'b0;
    n64      = {{(ACC_W-CNT_W){1'b0}}, total_q};
    nm164    = n64 - ACC_W'(1);
    mean_mag = mean_q[MEAN_W-1] ? (~mean_q + MEAN_W'(1)) : mean_q;
    mean_rnd = {1'b0, mean_mag} + ((MEAN_W+1)'(1) << (MEAN_EXTRA-1));
    rate_d   = {{(ACC_W-VALUE_WIDTH){prev_q[VALUE_WIDTH-1]}}, prev_q} -
               {{(ACC_W-VALUE_WIDTH){first_q[VALUE_WIDTH-1]}}, first_q};
    rate_num = (rate_d <<< 10) - (rate_d <<< 4) - (rate_d <<< 3);
    case (sel_q)
      AGG_COUNT: begin
        o_val = n64; o_valid = 1'b1;
      end
      AGG_SUM: begin
        o_val = sum_q; o_valid = 1'b1;
      end
      AGG_MEAN: begin
        o_val   = sat_signed(ACC_W'(mean_rnd >> MEAN_EXTRA), mean_q[MEAN_W-1]);
        o_valid = 1'b1;
      end
      AGG_MIN: begin
        o_val = {{(ACC_W-VALUE_WIDTH){least_q[VALUE_WIDTH-1]}}, least_q}; o_valid = 1'b1;
      end
      AGG_MAX: begin
        o_val = {{(ACC_W-VALUE_WIDTH){greatest_q[VALUE_WIDTH-1]}}, greatest_q};
        o_valid = 1'b1;
      end
      AGG_RANGE: begin
        o_val = {{(ACC_W-VALUE_WIDTH){greatest_q[VALUE_WIDTH-1]}}, greatest_q} -
                {{(ACC_W-VALUE_WIDTH){least_q[VALUE_WIDTH-1]}}, least_q};
        o_valid = 1'b1;
      end
      AGG_STDDEV: begin
        o_direct = 1'b0; o_valid = 1'b1; o_mag = m2_q; o_den = n64; o_sqrt = 1'b1;
      end
      AGG_VAR: begin
        o_direct = 1'b0; o_valid = 1'b1; o_mag = m2_q; o_den = n64 << FRACTION_BITS;
      end
      AGG_SSTDDEV: begin
        if (total_q > CNT_W'(1)) begin
          o_direct = 1'b0; o_valid = 1'b1; o_mag = m2_q; o_den = nm164; o_sqrt = 1'b1;
        end
      end
      AGG_SVAR: begin
        if (total_q > CNT_W'(1)) begin
          o_direct = 1'b0; o_valid = 1'b1; o_mag = m2_q; o_den = nm164 << FRACTION_BITS;
        end
      end
      AGG_TIME_AVG: begin
        if (elapsed_q != '0) begin
          o_direct = 1'b0; o_valid = 1'b1; o_mag = mag64(trap_q); o_neg = trap_q[ACC_W-1];
          o_den = {{(ACC_W-TIME_W-1){1'b0}}, elapsed_q, 1'b0};
        end
      end
      AGG_RATE: begin
        if (total_q > CNT_W'(1) && elapsed_q != '0) begin
          o_direct = 1'b0; o_valid = 1'b1; o_mag = mag64(rate_num);
          o_neg = rate_num[ACC_W-1]; o_den = {{(ACC_W-TIME_W){1'b0}}, elapsed_q};
        end
      end
      AGG_INTEGRAL: begin
        o_direct = 1'b0; o_valid = 1'b1; o_mag = mag64(trap_q); o_neg = trap_q[ACC_W-1];
        o_den = INTEGRAL_DEN;
      end
      default: begin
        o_valid = 1'b0;
      end
    endcase
  end

  // unit operand muxing
  always_comb begin
    mul_start  = (state_q == ST_FIRST) || (state_q == ST_M2ST);
    mul_a      = (state_q == ST_FIRST) ? ACC_W'(s_mag) : ACC_W'(delta_q[MEAN_W] ?
                 (~delta_q + (MEAN_W+1)'(1)) : delta_q);
    mul_b      = (state_q == ST_FIRST) ? ACC_W'(dt) : ACC_W'(delta2_mag);
    div_start  = (state_q == ST_FIRST) || ((state_q == ST_OUTSEL) && !o_direct);
    div_num    = (state_q == ST_FIRST) ? ACC_W'(delta_mag) : o_mag + (o_den >> 1);
    div_den    = (state_q == ST_FIRST) ? ACC_W'(n_new) : o_den;
    sqrt_start = (state_q == ST_OUTDIV) && !div_busy && sqrt_q;
    sqrt_rad   = sat_signed(div_q, 1'b0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_FIRST;
      ST_FIRST:  state_d = ST_WAIT1;
      ST_WAIT1:  if (!mul_busy && !div_busy) state_d = ST_M2ST;
      ST_M2ST:   state_d = ST_M2WAIT;
      ST_M2WAIT: if (!mul_busy) state_d = ST_OUTSEL;
      ST_OUTSEL: state_d = o_direct ? ST_DONE : ST_OUTDIV;
      ST_OUTDIV: if (!div_busy) state_d = sqrt_q ? ST_SQRT : ST_DONE;
      ST_SQRT:   if (!sqrt_busy) state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= AGG_MEAN;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      sum_q       <= '0;
      least_q     <= '0;
      greatest_q  <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      prev_time_q <= '0;
      trap_q      <= '0;
      elapsed_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        sel_q <= agg_sel_e'(cfg_data_i);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_PREP: begin
          if (restart_q) begin
            total_q     <= '0;
            mean_q      <= '0;
            m2_q        <= '0;
            sum_q       <= '0;
            least_q     <= '0;
            greatest_q  <= '0;
            first_q     <= '0;
            prev_q      <= '0;
            prev_time_q <= '0;
            trap_q      <= '0;
            elapsed_q   <= '0;
          end
        end
        ST_FIRST: begin
          if (first_win) begin
            first_q    <= x_q;
            least_q    <= x_q;
            greatest_q <= x_q;
          end else begin
            if (x_q < least_q) least_q <= x_q;
            if (x_q > greatest_q) greatest_q <= x_q;
          end
          if (trap_hit) elapsed_q <= el_next;
          total_q     <= n_new;
          sum_q       <= sat_add(sum_q, x64);
          prev_q      <= x_q;
          prev_time_q <= t_q;
        end
        ST_WAIT1: begin
          if (!mul_busy && !div_busy) begin
            if (trap_en_q) trap_q <= sat_add(trap_q, sat_signed(tmag, s_neg_q));
            mean_q <= mean_sum[MEAN_W-1:0];
          end
        end
        ST_M2WAIT: begin
          if (!mul_busy) begin
            m2_q <= (inc > room) ? ACC_MAX : m2_q + $signed(inc);
          end
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x_q       <= in_data_i.sample_value;
      t_q       <= in_data_i.sample_time_ms;
      restart_q <= in_data_i.window_restart;
    end
    if (state_q == ST_FIRST) begin
      trap_en_q <= trap_hit;
      s_neg_q   <= s[VALUE_WIDTH];
      delta_q   <= delta;
    end
    if (state_q == ST_OUTSEL) begin
      res_val_q   <= o_val;
      res_valid_q <= o_valid;
      div_neg_q   <= o_neg;
      sqrt_q      <= o_sqrt;
    end
    if (state_q == ST_OUTDIV && !div_busy && !sqrt_q) begin
      res_val_q <= sat_signed(div_q, div_neg_q);
    end
    if (state_q == ST_SQRT && !sqrt_busy) begin
      res_val_q <= ACC_W'(sqrt_root);
    end
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_data_q.aggregate_value <= res_val_q;
      out_data_q.aggregate_valid <= res_valid_q;
      out_data_q.samples_seen    <= total_q;
    end
  end

  rsa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (mul_p)
  );

  rsa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  rsa_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

endmodule

FILE: sv/rsa_checker.sv
// port-level checks for the running statistics accumulator, bound to the top level
module rsa_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input rsa_pkg::out_item_t        out_data_o
);
  import rsa_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transaction");

  // every result follows at least one sample
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.samples_seen != '0)
    else $error("result with zero samples");

  // undefined aggregates read as zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.aggregate_valid |-> out_data_o.aggregate_value == '0)
    else $error("invalid aggregate not zero");

endmodule

bind running_stats_accumulator rsa_checker u_rsa_checker (.*);

FILE: tb/sv/testbench.sv
// self-checking testbench for the running statistics accumulator
`timescale 1ns / 1ps

module testbench;
  import rsa_pkg::*;

  localparam int RANDOM_SAMPLES = 1400;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int MAX_REPORTS = 10;
  localparam longint S64_MAX = 64'sh7fffffffffffffff;
  localparam longint S64_MIN = 64'sh8000000000000000;
  localparam logic [47:0] TIME_MAX = 48'hffffffffffff;

  typedef struct {
    logic signed [31:0] value;
    logic [47:0]        stamp;
    logic               restart;
    agg_sel_e           sel;
    logic               set_sel;
    logic               has_fixed;
    logic signed [63:0] fixed_value;
    logic               fixed_valid;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [SEL_W-1:0] cfg_data_i = '0;

  running_stats_accumulator u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model state of the window
  agg_sel_e        sel_q;
  logic [31:0]     n_q;
  longint          mean_q, m2_q, sum_q, lo_q, hi_q, first_q, prev_q, trap_q;
  logic [47:0]     prev_t_q, elapsed_q;

  out_item_t       expected_results[$];
  longint          cycles = 0;
  int              mismatches = 0;
  int              table_errors = 0;
  int              results_seen = 0;
  int              valid_seen = 0;

  function automatic logic [127:0] umul(logic [63:0] a, logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint sat_mag(logic [63:0] m, logic neg);
    if (neg) return m >= 64'h8000000000000000 ? S64_MIN : -longint'(m);
    return m[63] ? S64_MAX : longint'(m);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < 65'(S64_MIN)) return S64_MIN;
    return longint'(s[63:0]);
  endfunction

  function automatic longint round_div(longint num, logic [63:0] den);
    return sat_mag((mag(num) + den / 2) / den, num < 0);
  endfunction

  function automatic logic [63:0] root_nearest(logic [63:0] v);
    logic [63:0] r, bitv, x;
    r = 0; bitv = 64'd1 << 62; x = v;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic void clear_window();
    n_q = 0; mean_q = 0; m2_q = 0; sum_q = 0; lo_q = 0; hi_q = 0;
    first_q = 0; prev_q = 0; prev_t_q = 0; trap_q = 0; elapsed_q = 0;
  endfunction

  function automatic out_item_t fold_sample(in_item_t s);
    longint x, sc, d1, d2, v;
    logic [127:0] p;
    logic [63:0] inc, dt, nn;
    logic ok;
    out_item_t r;
    x = longint'(s.sample_value);
    if (s.window_restart) clear_window();
    if (n_q == 0) begin
      first_q = x; lo_q = x; hi_q = x;
    end else if (s.sample_time_ms > prev_t_q) begin
      dt = 64'(s.sample_time_ms - prev_t_q);
      p = umul(mag(prev_q + x), dt);
      trap_q = sat_sum(trap_q, p[127:64] != 0 ? sat_mag('1, prev_q + x < 0)
                                             : sat_mag(p[63:0], prev_q + x < 0));
      elapsed_q = (dt > 64'(TIME_MAX - elapsed_q)) ? TIME_MAX : elapsed_q + 48'(dt);
    end
    if (n_q != 32'hffffffff) n_q++;
    nn = 64'(n_q);
    sc = x * 65536;
    d1 = sc - mean_q;
    mean_q += d1 / longint'(nn);
    d2 = sc - mean_q;
    p = umul(mag(d1), mag(d2));
    inc = p[127:96] != 0 ? '1 : p[95:32];
    m2_q = (inc > 64'(S64_MAX) - 64'(m2_q)) ? S64_MAX : m2_q + longint'(inc);
    sum_q = sat_sum(sum_q, x);
    if (x < lo_q) lo_q = x;
    if (x > hi_q) hi_q = x;
    prev_q = x;
    prev_t_q = s.sample_time_ms;
    v = 0; ok = 1'b1;
    case (sel_q)
      AGG_COUNT:    v = longint'(nn);
      AGG_SUM:      v = sum_q;
      AGG_MEAN:     v = round_div(mean_q, 64'd65536);
      AGG_MIN:      v = lo_q;
      AGG_MAX:      v = hi_q;
      AGG_RANGE:    v = hi_q - lo_q;
      AGG_STDDEV:   v = longint'(root_nearest(64'(round_div(m2_q, nn))));
      AGG_VAR:      v = round_div(m2_q, nn << FRACTION_BITS);
      AGG_SSTDDEV: begin
        ok = nn > 1;
        if (ok) v = longint'(root_nearest(64'(round_div(m2_q, nn - 1))));
      end
      AGG_SVAR: begin
        ok = nn > 1;
        if (ok) v = round_div(m2_q, (nn - 1) << FRACTION_BITS);
      end
      AGG_TIME_AVG: begin
        ok = elapsed_q > 0;
        if (ok) v = round_div(trap_q, 64'(elapsed_q) * 2);
      end
      AGG_RATE: begin
        ok = nn > 1 && elapsed_q > 0;
        if (ok) v = round_div((prev_q - first_q) * 1000, 64'(elapsed_q));
      end
      AGG_INTEGRAL: v = round_div(trap_q, 64'd2000);
      default:      ok = 1'b0;
    endcase
    r.aggregate_value = v;
    r.aggregate_valid = ok;
    r.samples_seen = n_q;
    return r;
  endfunction

  function automatic int pause_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  // result checking
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS) $display("unexpected result %p", out_data_o);
      end else begin
        if (out_data_o !== expected_results[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected %p, actual %p", expected_results[0], out_data_o);
        end
        if (expected_results[0].aggregate_valid) valid_seen <= valid_seen + 1;
        void'(expected_results.pop_front());
      end
    end
  end

  // result side back-pressure
  initial begin
    int g;
    forever begin
      g = pause_len();
      @(posedge clk_i);
      if (g != 0) begin
        out_stall_i <= $urandom_range(0, 9) > 2;
        repeat (g) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(50, 400) : 1) @(posedge clk_i);
    end
  end

  initial begin
    if (cycles == 0) begin
      wait (cycles >= CYCLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic write_select(agg_sel_e s);
    wait (expected_results.size() == 0);
    repeat (320) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sel_q = s;
  endtask

  task automatic send_sample(in_item_t s, logic gaps);
    int g;
    g = gaps ? pause_len() : 0;
    repeat (g + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(fold_sample(s));
    in_valid_i <= 1'b0;
  endtask

  stim_row_t directed[$];

  task automatic add_row(longint v, logic [47:0] t, logic rs, agg_sel_e s, logic set,
                         logic fx = 0, longint fv = 0, logic fval = 1);
    stim_row_t r;
    r.value = 32'(v); r.stamp = t; r.restart = rs; r.sel = s; r.set_sel = set;
    r.has_fixed = fx; r.fixed_value = fv; r.fixed_valid = fval;
    directed.push_back(r);
  endtask

  initial begin
    in_item_t s;
    out_item_t e;
    agg_sel_e sels[13];
    int k, phase_len;
    logic [47:0] t;
    for (int i = 0; i < 13; i++) sels[i] = agg_sel_e'(i);
    clear_window();
    sel_q = AGG_MEAN;

    // first sample after reset gives its own mean
    add_row(32'sh00030000, 48'd10, 0, AGG_MEAN, 0, 1, 64'sh30000, 1);
    add_row(32'sh7fffffff, 48'd20, 1, AGG_MAX, 1, 1, 64'sh7fffffff, 1);
    add_row(-32'sh80000000, 48'd20, 0, AGG_MIN, 1, 1, -64'sh80000000, 1);
    add_row(32'sh7fffffff, 48'd30, 0, AGG_RANGE, 1);
    add_row(0, 48'd5, 1, AGG_SSTDDEV, 1, 1, 0, 0);
    add_row(32'sh10000, 48'd5, 0, AGG_SVAR, 1);
    add_row(32'sh20000, 48'd1, 1, AGG_RATE, 1, 1, 0, 0);
    add_row(32'sh40000, 48'd1, 0, AGG_RATE, 0, 1, 0, 0);
    add_row(32'sh60000, 48'd1001, 0, AGG_RATE, 0);
    add_row(32'sh10000, 48'd0, 1, AGG_TIME_AVG, 1, 1, 0, 0);
    add_row(32'sh30000, TIME_MAX, 0, AGG_TIME_AVG, 0);
    add_row(-32'sh80000000, 48'd0, 0, AGG_INTEGRAL, 1);
    add_row(32'sh7fffffff, TIME_MAX, 0, AGG_INTEGRAL, 0);
    add_row(5, 48'd3, 1, AGG_COUNT, 1, 1, 1, 1);
    add_row(7, 48'd4, 0, AGG_SUM, 1, 1, 12, 1);
    add_row(-32'sh12345, 48'd9, 0, AGG_STDDEV, 1);
    add_row(32'sh55555, 48'd12, 0, AGG_VAR, 1);
    add_row(32'shaaaa, 48'hffffffff0000, 0, AGG_SSTDDEV, 1);
    add_row(-1, 48'h800000000000, 0, AGG_SVAR, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].set_sel) write_select(directed[i].sel);
      s.sample_value = directed[i].value;
      s.sample_time_ms = directed[i].stamp;
      s.window_restart = directed[i].restart;
      send_sample(s, 0);
      if (directed[i].has_fixed) begin
        e = expected_results[$];
        if (e.aggregate_value != directed[i].fixed_value ||
            e.aggregate_valid != directed[i].fixed_valid) begin
          $display("predictor disagrees with table row %0d", i);
          table_errors++;
        end
      end
    end

    // random phases, each under one aggregate selection
    k = 0;
    t = 0;
    while (k < RANDOM_SAMPLES) begin
      write_select(sels[$urandom_range(0, 12)]);
      phase_len = $urandom_range(20, 120);
      for (int j = 0; j < phase_len; j++) begin
        case ($urandom_range(0, 9))
          0: s.sample_value = $urandom;
          1: s.sample_value = $urandom_range(0, 1) ? 32'sh7fffffff : -32'sh80000000;
          default: s.sample_value = 32'($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
        case ($urandom_range(0, 9))
          0: t = 48'({$urandom, $urandom});
          1: t = t - 48'($urandom_range(0, 50));
          default: t = t + 48'($urandom_range(0, 2000));
        endcase
        s.sample_time_ms = t;
        s.window_restart = $urandom_range(0, 40) == 0;
        send_sample(s, 1);
        k++;
      end
    end

    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked, %0d of them valid aggregates",
             k + directed.size(), results_seen, valid_seen);
    if (mismatches == 0 && table_errors == 0 && expected_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", mismatches + table_errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
